FILE: sv/cbcs_pkg.sv
// shared constants, types and state codes for the cubic bezier curve sampler
package cbcs_pkg;

  localparam int COORD_W      = 32;
  localparam int WEIGHT_FRAC  = 16;
  localparam int WEIGHT_W     = WEIGHT_FRAC + 1;
  localparam int MAX_DETAIL   = 63;
  localparam int DETAIL_W     = $clog2(MAX_DETAIL + 1);
  localparam int TAB_ROWS     = MAX_DETAIL + 1;
  localparam int RESET_DETAIL = (20 < MAX_DETAIL) ? 20 : MAX_DETAIL;
  localparam int LANES        = 3;

  // weight build arithmetic
  localparam int N2_W        = 2 * DETAIL_W;
  localparam int DEN_W       = 3 * DETAIL_W;
  localparam int NUM_EXT_W   = DEN_W + 2;
  localparam int DIVIDEND_W  = DEN_W + WEIGHT_W;
  localparam int DIV_STEPS   = WEIGHT_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  // blend arithmetic
  localparam int PROD_W = COORD_W + WEIGHT_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef weight_t [3:0] weight_row_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  localparam weight_t WEIGHT_ONE = weight_t'(2 ** WEIGHT_FRAC);
  localparam weight_row_t PLAIN_ROW = {weight_t'(0), weight_t'(0), weight_t'(0), WEIGHT_ONE};

  localparam logic MODE_VERTEX = 1'b0;
  localparam logic MODE_BEZIER = 1'b1;

  typedef struct packed {
    logic                start;
    logic [DETAIL_W-1:0] detail;
  } build_req_t;

  typedef enum logic {
    C_IDLE,
    C_RUN
  } ctl_state_t;

  typedef enum logic [2:0] {
    W_IDLE,
    W_PREP,
    W_DEN,
    W_ROW,
    W_NUM,
    W_START,
    W_WAIT,
    W_WRITE
  } wtab_state_t;

endpackage

FILE: sv/cbcs_if.sv
// handshake channels of the curve sampler: input items, result items, detail writes
interface cbcs_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic signed [cbcs_pkg::COORD_W-1:0] ctrl1_x;
  logic signed [cbcs_pkg::COORD_W-1:0] ctrl1_y;
  logic signed [cbcs_pkg::COORD_W-1:0] ctrl1_z;
  logic signed [cbcs_pkg::COORD_W-1:0] ctrl2_x;
  logic signed [cbcs_pkg::COORD_W-1:0] ctrl2_y;
  logic signed [cbcs_pkg::COORD_W-1:0] ctrl2_z;
  logic signed [cbcs_pkg::COORD_W-1:0] point_x;
  logic signed [cbcs_pkg::COORD_W-1:0] point_y;
  logic signed [cbcs_pkg::COORD_W-1:0] point_z;

  modport source (output valid, mode, ctrl1_x, ctrl1_y, ctrl1_z, ctrl2_x, ctrl2_y, ctrl2_z,
                  point_x, point_y, point_z, input ready);
  modport sink (input valid, mode, ctrl1_x, ctrl1_y, ctrl1_z, ctrl2_x, ctrl2_y, ctrl2_z,
                point_x, point_y, point_z, output ready);
endinterface

interface cbcs_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cbcs_pkg::COORD_W-1:0] out_x;
  logic signed [cbcs_pkg::COORD_W-1:0] out_y;
  logic signed [cbcs_pkg::COORD_W-1:0] out_z;
  logic                             last;

  modport source (output valid, out_x, out_y, out_z, last, input ready);
  modport sink (input valid, out_x, out_y, out_z, last, output ready);
endinterface

interface cbcs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cbcs_pkg::DETAIL_W-1:0]     detail;

  modport source (output valid, detail, input ready);
  modport sink (input valid, detail, output ready);
endinterface

FILE: sv/cubic_bezier_curve_sampler.sv
// cubic bezier curve sampler top level: item control, x/y/z lanes and result register
//
// in_ch takes items. A plain vertex (mode 0) stores its point as the anchor and
// gives one result item, the point itself, with last set. A bezier item (mode 1)
// uses the anchor as the first control point and gives detail+1 samples, the
// final one with last set; that sample becomes the new anchor. A bezier item
// with no anchor yet is taken and gives nothing.
// cfg_ch writes detail (0 reads as 1). The weight table is then rebuilt by a
// shared bit-serial divider, one table row after another. The same rebuild for
// detail 20 runs after reset. in_ch.ready and cfg_ch.ready stay low during a
// rebuild, and a detail write waiting on cfg_ch holds off in_ch.
// Results: one sample per cycle while out_ch does not stall, from a single table
// read port, four stages from issue to out_ch (table read, products, partial sums,
// result register). The next item is taken once the last sample of an item
// reaches the result register.
// When out_ch.ready is low the whole sample pipeline holds in place.
module cubic_bezier_curve_sampler (
  input  logic      clk,
  input  logic      rst_n,
  cbcs_in_if.sink   in_ch,
  cbcs_out_if.source out_ch,
  cbcs_cfg_if.sink  cfg_ch
);

  cbcs_pkg::ctl_state_t state_r, state_nxt;

  logic [cbcs_pkg::DETAIL_W-1:0] detail_r;
  logic [cbcs_pkg::DETAIL_W-1:0] cfg_detail;
  logic [cbcs_pkg::DETAIL_W-1:0] i_r;
  logic [cbcs_pkg::DETAIL_W-1:0] last_idx_r;
  logic                          plain_r;
  logic                          anchor_valid_r;
  cbcs_pkg::coord_t              anchor_r [cbcs_pkg::LANES];
  cbcs_pkg::coord_t              op_a_r [cbcs_pkg::LANES];
  cbcs_pkg::coord_t              op_b_r [cbcs_pkg::LANES];
  cbcs_pkg::coord_t              op_c_r [cbcs_pkg::LANES];
  cbcs_pkg::coord_t              op_d_r [cbcs_pkg::LANES];
  cbcs_pkg::coord_t              in_b [cbcs_pkg::LANES];
  cbcs_pkg::coord_t              in_c [cbcs_pkg::LANES];
  cbcs_pkg::coord_t              in_d [cbcs_pkg::LANES];
  cbcs_pkg::coord_t              lane_res [cbcs_pkg::LANES];
  cbcs_pkg::coord_t              out_r [cbcs_pkg::LANES];

  logic s1_valid_r, s1_last_r, s1_plain_r;
  logic s2_valid_r, s2_last_r;
  logic s3_valid_r, s3_last_r;
  logic out_valid_r, out_last_r;

  logic                  adv;
  logic                  idle;
  logic                  in_acc;
  logic                  cfg_acc;
  logic                  start_item;
  logic                  issue;
  logic                  tab_busy;
  cbcs_pkg::build_req_t  build;
  cbcs_pkg::weight_row_t tab_row;
  cbcs_pkg::weight_row_t w_row;

  assign in_b = '{in_ch.ctrl1_x, in_ch.ctrl1_y, in_ch.ctrl1_z};
  assign in_c = '{in_ch.ctrl2_x, in_ch.ctrl2_y, in_ch.ctrl2_z};
  assign in_d = '{in_ch.point_x, in_ch.point_y, in_ch.point_z};

  // the whole sample pipeline moves only when the result register can take a sample
  assign adv  = !out_valid_r || out_ch.ready;
  assign idle = (state_r == cbcs_pkg::C_IDLE) && !s1_valid_r && !s2_valid_r && !s3_valid_r
              && !tab_busy;

  // a waiting detail write goes first so an item never runs during a rebuild
  assign in_ch.ready  = idle && !cfg_ch.valid;
  assign cfg_ch.ready = idle;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_acc      = cfg_ch.valid && idle;
  assign start_item   = in_acc && (in_ch.mode == cbcs_pkg::MODE_VERTEX || anchor_valid_r);

  assign cfg_detail   = (cfg_ch.detail == '0) ? cbcs_pkg::DETAIL_W'(1) : cfg_ch.detail;
  assign build.start  = cfg_acc;
  assign build.detail = cfg_detail;

  cbcs_wtab u_wtab (
    .clk     (clk),
    .rst_n   (rst_n),
    .build   (build),
    .rd_en   (issue),
    .rd_addr (i_r),
    .busy    (tab_busy),
    .rd_row  (tab_row)
  );

  assign w_row = s1_plain_r ? cbcs_pkg::PLAIN_ROW : tab_row;

  for (genvar g = 0; g < cbcs_pkg::LANES; g++) begin : g_lane
    cbcs_lane u_lane (
      .clk (clk),
      .en  (adv),
      .a   (op_a_r[g]),
      .b   (op_b_r[g]),
      .c   (op_c_r[g]),
      .d   (op_d_r[g]),
      .w   (w_row),
      .res (lane_res[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbcs_pkg::C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    issue     = 1'b0;
    unique case (state_r)
      cbcs_pkg::C_IDLE: if (start_item) state_nxt = cbcs_pkg::C_RUN;
      cbcs_pkg::C_RUN: begin
        issue = adv;
        if (adv && i_r == last_idx_r) state_nxt = cbcs_pkg::C_IDLE;
      end
      default: state_nxt = cbcs_pkg::C_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detail_r       <= cbcs_pkg::DETAIL_W'(cbcs_pkg::RESET_DETAIL);
      anchor_valid_r <= 1'b0;
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      s3_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      i_r            <= '0;
    end else begin
      if (cfg_acc) begin
        detail_r <= cfg_detail;
      end
      if (in_acc && in_ch.mode == cbcs_pkg::MODE_VERTEX) begin
        anchor_valid_r <= 1'b1;
      end
      if (start_item) begin
        i_r <= '0;
      end else if (issue) begin
        i_r <= i_r + 1'b1;
      end
      if (adv) begin
        s1_valid_r  <= issue;
        s2_valid_r  <= s1_valid_r;
        s3_valid_r  <= s2_valid_r;
        out_valid_r <= s3_valid_r;
      end
    end
  end

  // anchor starts at zero and follows the last sample of every item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_r <= '{default: '0};
    end else if (adv && s3_valid_r && s3_last_r) begin
      anchor_r <= lane_res;
    end
  end

  always_ff @(posedge clk) begin
    if (start_item) begin
      plain_r    <= (in_ch.mode == cbcs_pkg::MODE_VERTEX);
      last_idx_r <= (in_ch.mode == cbcs_pkg::MODE_VERTEX) ? '0 : detail_r;
      op_a_r     <= (in_ch.mode == cbcs_pkg::MODE_VERTEX) ? in_d : anchor_r;
      op_b_r     <= in_b;
      op_c_r     <= in_c;
      op_d_r     <= in_d;
    end
    if (adv) begin
      s1_last_r  <= (i_r == last_idx_r);
      s1_plain_r <= plain_r;
      s2_last_r  <= s1_last_r;
      s3_last_r  <= s2_last_r;
      out_last_r <= s3_last_r;
      out_r      <= lane_res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_x = out_r[0];
  assign out_ch.out_y = out_r[1];
  assign out_ch.out_z = out_r[2];
  assign out_ch.last  = out_last_r;

endmodule

FILE: sv/cbcs_wdiv.sv
// restoring divider, one quotient bit per cycle, for the bernstein weight build
module cbcs_wdiv (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [cbcs_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [cbcs_pkg::DEN_W-1:0]          divisor,
  output logic                                done,
  output logic [cbcs_pkg::WEIGHT_W-1:0]       quot
);

  logic [cbcs_pkg::DEN_W-1:0]     rem_r;
  logic [cbcs_pkg::WEIGHT_W-1:0]  low_r;
  logic [cbcs_pkg::WEIGHT_W-1:0]  q_r;
  logic [cbcs_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           done_r;
  logic [cbcs_pkg::DEN_W:0]       trial;
  logic [cbcs_pkg::DEN_W:0]       diff;
  logic                           fits;

  assign trial = {rem_r, low_r[cbcs_pkg::WEIGHT_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= cbcs_pkg::DIV_CNT_W'(cbcs_pkg::DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == cbcs_pkg::DIV_CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // upper dividend bits are already below the divisor, so only the low bits iterate
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[cbcs_pkg::DIVIDEND_W-1:cbcs_pkg::WEIGHT_W];
      low_r <= dividend[cbcs_pkg::WEIGHT_W-1:0];
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? diff[cbcs_pkg::DEN_W-1:0] : trial[cbcs_pkg::DEN_W-1:0];
      low_r <= {low_r[cbcs_pkg::WEIGHT_W-2:0], 1'b0};
      q_r   <= {q_r[cbcs_pkg::WEIGHT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: sv/cbcs_wtab.sv
// bernstein weight table: build sequencer and one-row-per-cycle read port
module cbcs_wtab (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cbcs_pkg::build_req_t              build,
  input  logic                              rd_en,
  input  logic [cbcs_pkg::DETAIL_W-1:0]     rd_addr,
  output logic                              busy,
  output cbcs_pkg::weight_row_t             rd_row
);

  cbcs_pkg::wtab_state_t state_r, state_nxt;

  logic [cbcs_pkg::DETAIL_W-1:0]   n_r;
  logic [cbcs_pkg::DETAIL_W-1:0]   i_r;
  logic [cbcs_pkg::DETAIL_W-1:0]   s_r;
  logic [cbcs_pkg::N2_W-1:0]       n2_r;
  logic [cbcs_pkg::N2_W-1:0]       s2_r;
  logic [cbcs_pkg::N2_W-1:0]       i2_r;
  logic [cbcs_pkg::DEN_W-1:0]      den_r;
  logic [cbcs_pkg::DEN_W-1:0]      num_r;
  logic [1:0]                      k_r;
  cbcs_pkg::weight_row_t           row_r;
  logic [cbcs_pkg::NUM_EXT_W-1:0]  num_ext;
  logic [cbcs_pkg::DIVIDEND_W-1:0] dividend;
  logic                            div_start;
  logic                            div_done;
  logic [cbcs_pkg::WEIGHT_W-1:0]   div_quot;

  cbcs_pkg::weight_row_t mem [cbcs_pkg::TAB_ROWS];

  cbcs_wdiv u_wdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (den_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  // round to nearest: (num * 2^16 + den / 2) / den
  assign dividend = cbcs_pkg::DIVIDEND_W'({num_r, {cbcs_pkg::WEIGHT_FRAC{1'b0}}})
                  + cbcs_pkg::DIVIDEND_W'(den_r >> 1);

  always_comb begin
    case (k_r)
      2'd0:    num_ext = cbcs_pkg::NUM_EXT_W'(s2_r) * cbcs_pkg::NUM_EXT_W'(s_r);
      2'd1:    num_ext = cbcs_pkg::NUM_EXT_W'(3) * cbcs_pkg::NUM_EXT_W'(s2_r)
                       * cbcs_pkg::NUM_EXT_W'(i_r);
      2'd2:    num_ext = cbcs_pkg::NUM_EXT_W'(3) * cbcs_pkg::NUM_EXT_W'(i2_r)
                       * cbcs_pkg::NUM_EXT_W'(s_r);
      default: num_ext = cbcs_pkg::NUM_EXT_W'(i2_r) * cbcs_pkg::NUM_EXT_W'(i_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbcs_pkg::W_PREP;
      n_r     <= cbcs_pkg::DETAIL_W'(cbcs_pkg::RESET_DETAIL);
    end else begin
      state_r <= state_nxt;
      if (state_r == cbcs_pkg::W_IDLE && build.start) begin
        n_r <= build.detail;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      cbcs_pkg::W_IDLE:  if (build.start) state_nxt = cbcs_pkg::W_PREP;
      cbcs_pkg::W_PREP:  state_nxt = cbcs_pkg::W_DEN;
      cbcs_pkg::W_DEN:   state_nxt = cbcs_pkg::W_ROW;
      cbcs_pkg::W_ROW:   state_nxt = cbcs_pkg::W_NUM;
      cbcs_pkg::W_NUM:   state_nxt = cbcs_pkg::W_START;
      cbcs_pkg::W_START: begin
        div_start = 1'b1;
        state_nxt = cbcs_pkg::W_WAIT;
      end
      cbcs_pkg::W_WAIT: begin
        if (div_done) begin
          state_nxt = (k_r == 2'd3) ? cbcs_pkg::W_WRITE : cbcs_pkg::W_NUM;
        end
      end
      cbcs_pkg::W_WRITE: state_nxt = (i_r == n_r) ? cbcs_pkg::W_IDLE : cbcs_pkg::W_ROW;
      default:           state_nxt = cbcs_pkg::W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      cbcs_pkg::W_PREP: begin
        n2_r <= cbcs_pkg::N2_W'(n_r) * cbcs_pkg::N2_W'(n_r);
        i_r  <= '0;
      end
      cbcs_pkg::W_DEN: den_r <= cbcs_pkg::DEN_W'(n2_r) * cbcs_pkg::DEN_W'(n_r);
      cbcs_pkg::W_ROW: begin
        s_r  <= n_r - i_r;
        s2_r <= cbcs_pkg::N2_W'(n_r - i_r) * cbcs_pkg::N2_W'(n_r - i_r);
        i2_r <= cbcs_pkg::N2_W'(i_r) * cbcs_pkg::N2_W'(i_r);
        k_r  <= '0;
      end
      cbcs_pkg::W_NUM: num_r <= num_ext[cbcs_pkg::DEN_W-1:0];
      cbcs_pkg::W_WAIT: begin
        if (div_done) begin
          row_r[k_r] <= div_quot;
          k_r        <= k_r + 1'b1;
        end
      end
      cbcs_pkg::W_WRITE: i_r <= i_r + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == cbcs_pkg::W_WRITE) begin
      mem[i_r] <= row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

  assign busy = (state_r != cbcs_pkg::W_IDLE);

endmodule

FILE: sv/cbcs_lane.sv
// one coordinate lane: four weighted products, adder tree, rounding and saturation
module cbcs_lane (
  input  logic                  clk,
  input  logic                  en,
  input  cbcs_pkg::coord_t      a,
  input  cbcs_pkg::coord_t      b,
  input  cbcs_pkg::coord_t      c,
  input  cbcs_pkg::coord_t      d,
  input  cbcs_pkg::weight_row_t w,
  output cbcs_pkg::coord_t      res
);

  cbcs_pkg::coord_t                     op [4];
  logic signed [cbcs_pkg::PROD_W-1:0]   prod_r [4];
  logic signed [cbcs_pkg::SUM_W-1:0]    pair_r [2];
  logic signed [cbcs_pkg::SUM_W-1:0]    rnd;
  logic signed [cbcs_pkg::SUM_W-1:0]    sh;
  logic [cbcs_pkg::SUM_W-cbcs_pkg::COORD_W:0] upper;

  assign op[0] = a;
  assign op[1] = b;
  assign op[2] = c;
  assign op[3] = d;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= op[k] * $signed({1'b0, w[k]});
      end
      pair_r[0] <= cbcs_pkg::SUM_W'(prod_r[0]) + cbcs_pkg::SUM_W'(prod_r[1]);
      pair_r[1] <= cbcs_pkg::SUM_W'(prod_r[2]) + cbcs_pkg::SUM_W'(prod_r[3]);
    end
  end

  // halves round toward +infinity
  assign rnd   = pair_r[0] + pair_r[1]
               + cbcs_pkg::SUM_W'(2 ** (cbcs_pkg::WEIGHT_FRAC - 1));
  assign sh    = rnd >>> cbcs_pkg::WEIGHT_FRAC;
  assign upper = sh[cbcs_pkg::SUM_W-1:cbcs_pkg::COORD_W-1];

  always_comb begin
    if (upper == '0 || upper == '1) begin
      res = sh[cbcs_pkg::COORD_W-1:0];
    end else if (sh[cbcs_pkg::SUM_W-1]) begin
      res = {1'b1, {(cbcs_pkg::COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(cbcs_pkg::COORD_W-1){1'b1}}};
    end
  end

endmodule

FILE: tb/tb.sv
// self-checking testbench for the cubic bezier curve sampler
`timescale 1ns / 100ps

module tb;
  import cbcs_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int TAIL_CYCLES   = 40;
  localparam int PHASE_ITEMS   = 44;
  localparam int N_DIR         = 16;
  localparam int N_PHASES      = 6;

  typedef coord_t [0:2] vec_t;

  typedef struct packed {
    logic mode;
    vec_t c1;
    vec_t c2;
    vec_t pt;
  } arc_item_t;

  typedef struct packed {
    vec_t p;
    logic last;
  } vtx_t;

  // typed rows carry their expected vertex, or none for an arc with no anchor
  typedef struct packed {
    logic      typed;
    logic      one_result;
    arc_item_t item;
    vec_t      ex;
  } dir_row_t;

  localparam coord_t CMAX = 32'sh7fff_ffff;
  localparam coord_t CMIN = 32'sh8000_0000;
  localparam vec_t   V0   = '{32'sd0, 32'sd0, 32'sd0};
  localparam vec_t   VMAX = '{CMAX, CMAX, CMAX};
  localparam vec_t   VMIN = '{CMIN, CMIN, CMIN};
  localparam vec_t   VALT = '{32'shAAAA_AAAA, 32'sh5555_5555, 32'sh0000_FFFF};
  localparam vec_t   VINV = '{32'sh5555_5555, 32'shAAAA_AAAA, 32'shFFFF_0000};

  dir_row_t dir_tab [N_DIR] = '{
    // arcs before any vertex: nothing comes out
    '{1'b1, 1'b0, '{MODE_BEZIER, '{CMAX, CMIN, 32'sd1}, '{CMIN, CMAX, -32'sd1},
                    '{32'sd5, 32'sd6, 32'sd7}}, V0},
    '{1'b1, 1'b0, '{MODE_BEZIER, VMIN, VMIN, VMIN}, V0},
    '{1'b1, 1'b1, '{MODE_VERTEX, VMAX, VMIN, V0}, V0},
    '{1'b0, 1'b0, '{MODE_BEZIER, '{32'sh1_0000, 32'sd0, 32'sd0},
                    '{32'sh2_0000, 32'sh1_0000, 32'sd0},
                    '{32'sh3_0000, 32'sh3_0000, 32'sh1_0000}}, V0},
    '{1'b1, 1'b1, '{MODE_VERTEX, V0, V0, VMAX}, VMAX},
    '{1'b0, 1'b0, '{MODE_BEZIER, VMAX, VMAX, VMAX}, V0},
    '{1'b1, 1'b1, '{MODE_VERTEX, VMAX, VMAX, VMIN}, VMIN},
    '{1'b0, 1'b0, '{MODE_BEZIER, VMIN, VMIN, VMIN}, V0},
    // full swings from one rail to the other
    '{1'b0, 1'b0, '{MODE_BEZIER, VMAX, VMAX, VMAX}, V0},
    '{1'b0, 1'b0, '{MODE_BEZIER, VMIN, VMAX, VMIN}, V0},
    '{1'b1, 1'b1, '{MODE_VERTEX, VMIN, VMAX, '{CMAX, CMIN, -32'sd1}},
                    '{CMAX, CMIN, -32'sd1}},
    '{1'b0, 1'b0, '{MODE_BEZIER, '{-32'sd1, -32'sd1, -32'sd1}, '{CMIN, CMAX, 32'sd0},
                    '{32'sd1, -32'sd1, 32'sh8000}}, V0},
    '{1'b1, 1'b1, '{MODE_VERTEX, VINV, VALT, VALT}, VALT},
    '{1'b0, 1'b0, '{MODE_BEZIER, VINV, VALT, VINV}, V0},
    '{1'b0, 1'b0, '{MODE_BEZIER, '{32'sh8000, -32'sh8000, 32'sd1},
                    '{-32'sh7fff, 32'sh7fff, -32'sd1}, '{32'sd3, -32'sd3, 32'sd0}}, V0},
    '{1'b1, 1'b1, '{MODE_VERTEX, VALT, VINV, '{-32'sd1, 32'sd1, 32'sh7fff_8000}},
                    '{-32'sd1, 32'sd1, 32'sh7fff_8000}}
  };

  logic clk;
  logic rst_n;

  cbcs_in_if  in_ch ();
  cbcs_out_if out_ch ();
  cbcs_cfg_if cfg_ch ();

  cubic_bezier_curve_sampler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  int      seg_count;
  weight_t bern_w [0:MAX_DETAIL][0:3];
  vec_t    anchor;
  bit      anchor_set;
  vtx_t    arc_samples [$];
  vtx_t    pending [$];

  int in_gap_pct;
  int out_stall_pct;
  int errors;
  int cycle;
  int n_items;
  int n_arcs;
  int n_results;
  int n_detail_writes;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic weight_t round_weight(input longint unsigned num,
                                           input longint unsigned den);
    return weight_t'(((num << WEIGHT_FRAC) + den / 2) / den);
  endfunction

  function automatic void build_bernstein(input int n);
    longint unsigned nn;
    longint unsigned den;
    longint unsigned s;
    longint unsigned i;
    nn  = longint'(n);
    den = nn * nn * nn;
    for (i = 0; i <= nn; i++) begin
      s = nn - i;
      bern_w[i][0] = round_weight(s * s * s, den);
      bern_w[i][1] = round_weight(3 * s * s * i, den);
      bern_w[i][2] = round_weight(3 * s * i * i, den);
      bern_w[i][3] = round_weight(i * i * i, den);
    end
  endfunction

  // exact weighted sum, round half up, clamp to the coordinate range
  function automatic coord_t weighted_coord(input coord_t a, input coord_t b, input coord_t c,
                                            input coord_t d, input int row);
    longint acc;
    acc = longint'(a) * longint'(bern_w[row][0]) + longint'(b) * longint'(bern_w[row][1])
        + longint'(c) * longint'(bern_w[row][2]) + longint'(d) * longint'(bern_w[row][3]);
    acc = (acc + 64'sd32768) >>> WEIGHT_FRAC;
    if (acc > 64'sd2147483647)
      return CMAX;
    if (acc < -64'sd2147483648)
      return CMIN;
    return coord_t'(acc);
  endfunction

  function automatic void tessellate(input arc_item_t it);
    vec_t a0;
    vtx_t v;
    arc_samples.delete();
    if (it.mode == MODE_VERTEX) begin
      anchor     = it.pt;
      anchor_set = 1'b1;
      v.p        = it.pt;
      v.last     = 1'b1;
      arc_samples.insert(arc_samples.size(), v);
    end else if (anchor_set) begin
      a0 = anchor;
      for (int i = 0; i <= seg_count; i++) begin
        for (int k = 0; k < 3; k++)
          v.p[k] = weighted_coord(a0[k], it.c1[k], it.c2[k], it.pt[k], i);
        v.last = (i == seg_count);
        arc_samples.insert(arc_samples.size(), v);
      end
      anchor = v.p;
    end
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return CMAX;
      1: return CMIN;
      2, 3: return coord_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic vec_t rand_vec();
    vec_t v;
    for (int k = 0; k < 3; k++)
      v[k] = rand_coord();
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR cycle %0d: %s", cycle, msg);
  endtask

  task automatic send_item(input arc_item_t it, input bit typed, input bit one_result,
                           input vec_t typed_p);
    vtx_t v;
    if (in_gap_pct != 0 && $urandom_range(1, 100) <= in_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= it.mode;
    in_ch.ctrl1_x <= it.c1[0];
    in_ch.ctrl1_y <= it.c1[1];
    in_ch.ctrl1_z <= it.c1[2];
    in_ch.ctrl2_x <= it.c2[0];
    in_ch.ctrl2_y <= it.c2[1];
    in_ch.ctrl2_z <= it.c2[2];
    in_ch.point_x <= it.pt[0];
    in_ch.point_y <= it.pt[1];
    in_ch.point_z <= it.pt[2];
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
    if (it.mode == MODE_BEZIER)
      n_arcs++;
    tessellate(it);
    if (typed) begin
      if (one_result) begin
        v.p    = typed_p;
        v.last = 1'b1;
        pending.insert(pending.size(), v);
      end
    end else begin
      foreach (arc_samples[j])
        pending.insert(pending.size(), arc_samples[j]);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_detail(input logic [DETAIL_W-1:0] v);
    drain();
    // an arc with no anchor leaves nothing to wait for, so give it time to finish
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.detail <= v;
    cfg_ch.valid  <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    seg_count = (v == 0) ? 1 : int'(v);
    build_bernstein(seg_count);
    n_detail_writes++;
  endtask

  // result side: random stall bursts
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (out_stall_pct != 0 && $urandom_range(1, 100) <= out_stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    vtx_t want;
    vec_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      got = '{out_ch.out_x, out_ch.out_y, out_ch.out_z};
      if (pending.size() == 0) begin
        report_mismatch($sformatf("vertex (%0d, %0d, %0d) with nothing pending",
                                  got[0], got[1], got[2]));
      end else begin
        want = pending.pop_front();
        for (int k = 0; k < 3; k++)
          if (got[k] !== want.p[k])
            report_mismatch($sformatf("result %0d coord %0d: got %0d, expected %0d",
                                      n_results, k, got[k], want.p[k]));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("result %0d last: got %b, expected %b",
                                    n_results, out_ch.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle++;
    if (cycle >= CYCLE_LIMIT) begin
      $display("cycle limit hit with %0d vertices still pending", pending.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    arc_item_t it;
    logic [DETAIL_W-1:0] plan [N_PHASES];
    int gap_plan [N_PHASES];
    int n;
    int k;

    plan     = '{6'd63, 6'd0, 6'd1, 6'd9, 6'd33, 6'd20};
    gap_plan = '{20, 0, 30, 10, 25, 0};
    plan[N_PHASES-1] = DETAIL_W'($urandom_range(2, 40));

    errors          = 0;
    cycle           = 0;
    n_items         = 0;
    n_arcs          = 0;
    n_results       = 0;
    n_detail_writes = 0;
    in_gap_pct      = 15;
    out_stall_pct   = 15;
    anchor          = V0;
    anchor_set      = 1'b0;
    seg_count       = RESET_DETAIL;
    build_bernstein(seg_count);

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= MODE_VERTEX;
    in_ch.ctrl1_x <= '0;
    in_ch.ctrl1_y <= '0;
    in_ch.ctrl1_z <= '0;
    in_ch.ctrl2_x <= '0;
    in_ch.ctrl2_y <= '0;
    in_ch.ctrl2_z <= '0;
    in_ch.point_x <= '0;
    in_ch.point_y <= '0;
    in_ch.point_z <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.detail <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r])
      send_item(dir_tab[r].item, dir_tab[r].typed, dir_tab[r].one_result, dir_tab[r].ex);

    for (int p = 0; p < N_PHASES; p++) begin
      write_detail(plan[p]);
      in_gap_pct    = gap_plan[p];
      out_stall_pct = gap_plan[p];
      n = 0;
      while (n < PHASE_ITEMS) begin
        // a path: one vertex, then a chain of arcs off it
        it.mode = MODE_VERTEX;
        it.c1   = rand_vec();
        it.c2   = rand_vec();
        it.pt   = rand_vec();
        send_item(it, 1'b0, 1'b0, V0);
        n++;
        k = $urandom_range(1, 5);
        repeat (k) begin
          it.mode = MODE_BEZIER;
          it.c1   = rand_vec();
          it.c2   = rand_vec();
          it.pt   = rand_vec();
          if ($urandom_range(0, 7) == 0) begin
            it.c1 = ($urandom_range(0, 1) != 0) ? VMAX : VMIN;
            it.c2 = it.c1;
            it.pt = ($urandom_range(0, 1) != 0) ? it.c1 : VMAX;
          end
          send_item(it, 1'b0, 1'b0, V0);
          n++;
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d items sent (%0d arcs), %0d vertices checked over %0d cycles",
             n_items, n_arcs, n_results, cycle);
    $display("detail written %0d times incl. 0, 1 and 63; gaps and stalls varied per phase",
             n_detail_writes);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
